@@ design/text_point_row_column_scanner_top_defines.svh @@
// Assertion macros used by the scanner back end.
`ifndef TEXT_POINT_ROW_COLUMN_SCANNER_TOP_DEFINES_SVH
`define TEXT_POINT_ROW_COLUMN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk.
`define TPRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk.
`define TPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tprc_pkg.sv @@
`default_nettype none
package tprc_pkg;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [3:0] TOK_MAX      = 4'd15;
	localparam logic [3:0] COLS_DEFAULT = 4'd3;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_UNSUPPORTED  = 2'd1,
		ERR_INCONSISTENT = 2'd2
	} scan_err_t;

	typedef struct packed {
		logic       data_line;
		logic [3:0] tokens;
		logic       last;
	} line_evt_t;

	function automatic logic cols_supported(input logic [3:0] n);
		return (n == 4'd3) || (n == 4'd4) || (n == 4'd6) || (n == 4'd7) || (n == 4'd9);
	endfunction

endpackage
`default_nettype wire

@@ design/tprc_front.sv @@
`default_nettype none
module tprc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_input,
	output tprc_pkg::line_evt_t      evt
);
	import tprc_pkg::*;

	logic       line_start_q;
	logic       comment_q;
	logic       in_tok_q;
	logic [3:0] tok_q;

	logic       upd_start;
	logic       upd_comment;
	logic       upd_in_tok;
	logic [3:0] upd_tok;
	logic       is_lf;
	logic       is_ws;
	logic       is_sep;
	logic       closing;
	logic       cl_comment;
	logic [3:0] cl_tok;

	always_comb begin
		is_lf       = (text_byte == CH_LF);
		is_ws       = (text_byte == CH_SPACE) || (text_byte == CH_TAB) || (text_byte == CH_CR);
		is_sep      = is_ws || (text_byte == CH_COMMA);
		upd_start   = line_start_q;
		upd_comment = comment_q;
		upd_in_tok  = in_tok_q;
		upd_tok     = tok_q;
		if (!is_lf && !comment_q) begin
			if (line_start_q && is_ws) begin
				upd_start = 1'b1;
			end else if (line_start_q && (text_byte == CH_HASH)) begin
				upd_comment = 1'b1;
			end else begin
				upd_start = 1'b0;
				if (is_sep) begin
					upd_in_tok = 1'b0;
				end else if (!in_tok_q) begin
					upd_in_tok = 1'b1;
					if (tok_q != TOK_MAX) begin
						upd_tok = tok_q + 4'd1;
					end
				end
			end
		end
		closing    = is_lf || end_of_input;
		cl_comment = is_lf ? comment_q : upd_comment;
		cl_tok     = is_lf ? tok_q : upd_tok;
		evt.data_line = closing && !cl_comment && (cl_tok != 4'd0);
		evt.tokens    = cl_tok;
		evt.last      = end_of_input;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			comment_q    <= 1'b0;
			in_tok_q     <= 1'b0;
			tok_q        <= 4'd0;
		end else if (take) begin
			if (closing) begin
				line_start_q <= 1'b1;
				comment_q    <= 1'b0;
				in_tok_q     <= 1'b0;
				tok_q        <= 4'd0;
			end else begin
				line_start_q <= upd_start;
				comment_q    <= upd_comment;
				in_tok_q     <= upd_in_tok;
				tok_q        <= upd_tok;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/tprc_fifo.sv @@
`default_nettype none
module tprc_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr,
	input  wire tprc_pkg::line_evt_t wr_data,
	output logic                     full,
	input  wire logic                rd,
	output tprc_pkg::line_evt_t      rd_data,
	output logic                     empty
);
	import tprc_pkg::*;

	line_evt_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wptr_q;
	logic [FIFO_PTR_W-1:0]   rptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd && !empty) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/tprc_back.sv @@
`default_nettype none
`include "text_point_row_column_scanner_top_defines.svh"
module tprc_back #(
	parameter int ROW_COUNT_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tprc_pkg::line_evt_t evt,
	input  wire logic                evt_empty,
	output logic                     evt_rd,
	input  wire logic                pop,
	output logic                     empty,
	output logic [31:0]              row_count,
	output logic [3:0]               col_count,
	output logic [1:0]               scan_error,
	output logic                     scan_done
);
	import tprc_pkg::*;

	logic [ROW_COUNT_WIDTH-1:0] rows_q;
	logic [3:0]                 fixed_q;
	scan_err_t                  err_q;
	logic                       out_vld_q;

	logic [ROW_COUNT_WIDTH-1:0] rows_n;
	logic [3:0]                 fixed_n;
	scan_err_t                  err_n;

	assign evt_rd = !evt_empty && (!out_vld_q || pop);
	assign empty  = !out_vld_q;

	always_comb begin
		rows_n  = rows_q;
		fixed_n = fixed_q;
		err_n   = err_q;
		if (evt.data_line && (err_q == ERR_NONE)) begin
			if (fixed_q == 4'd0) begin
				if (cols_supported(evt.tokens)) begin
					fixed_n = evt.tokens;
				end else begin
					err_n = ERR_UNSUPPORTED;
				end
			end else if (evt.tokens != fixed_q) begin
				err_n = ERR_INCONSISTENT;
			end
			if ((err_n == ERR_NONE) && (rows_q != '1)) begin
				rows_n = rows_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= '0;
			fixed_q   <= 4'd0;
			err_q     <= ERR_NONE;
			out_vld_q <= 1'b0;
		end else begin
			if (evt_rd) begin
				out_vld_q <= 1'b1;
				if (evt.last) begin
					rows_q  <= '0;
					fixed_q <= 4'd0;
					err_q   <= ERR_NONE;
				end else begin
					rows_q  <= rows_n;
					fixed_q <= fixed_n;
					err_q   <= err_n;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_rd) begin
			row_count  <= 32'(rows_n);
			col_count  <= (fixed_n == 4'd0) ? COLS_DEFAULT : fixed_n;
			scan_error <= err_n;
			scan_done  <= evt.last;
		end
	end

	`TPRC_ASSERT_NEXT(a_clear_after_last, evt_rd && evt.last,
		(rows_q == '0) && (fixed_q == 4'd0) && (err_q == ERR_NONE),
		"scan state not cleared after end of input")
	`TPRC_ASSERT_NEXT(a_err_sticky, (err_q != ERR_NONE) && !(evt_rd && evt.last),
		(err_q == $past(err_q)) && $stable(rows_q) && $stable(fixed_q),
		"state changed while error is set")
	`TPRC_ASSERT_NOW(a_fixed_legal, fixed_q != 4'd0, cols_supported(fixed_q),
		"fixed column count is not a supported value")

endmodule
`default_nettype wire

@@ design/text_point_row_column_scanner_top.sv @@
// Channel   Direction  Handshake        Payload
// input     in         push / full      text_byte[7:0], end_of_input
// result    out        pop / empty      row_count[31:0], col_count[3:0],
//                                       scan_error[1:0], scan_done
//
// One byte accepted per cycle unless full; its result passes the queue and result register.
// Line lexing runs on the accepted byte in the front; a two-entry queue feeds
// the back, which holds column, row and error state and a result register.
// arst_n clears all scan state; after the end-of-input byte the state clears.
// full rises once two requests wait behind an unpopped result; a pop reads one and clears full.
`default_nettype none
module text_point_row_column_scanner_top #(
	parameter int ROW_COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_input,
	input  wire logic        pop,
	output logic             empty,
	output logic [31:0]      row_count,
	output logic [3:0]       col_count,
	output logic [1:0]       scan_error,
	output logic             scan_done
);
	import tprc_pkg::*;

	line_evt_t front_evt;
	line_evt_t back_evt;
	logic      take;
	logic      q_empty;
	logic      q_rd;

	assign take = push && !full;

	tprc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.evt          (front_evt)
	);

	tprc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_data (front_evt),
		.full    (full),
		.rd      (q_rd),
		.rd_data (back_evt),
		.empty   (q_empty)
	);

	tprc_back #(
		.ROW_COUNT_WIDTH (ROW_COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (back_evt),
		.evt_empty    (q_empty),
		.evt_rd       (q_rd),
		.pop          (pop),
		.empty        (empty),
		.row_count    (row_count),
		.col_count    (col_count),
		.scan_error   (scan_error),
		.scan_done    (scan_done)
	);

endmodule
`default_nettype wire
